### src/sle_pkg.sv
// ----------------------------------------------------------------------------
// sle_pkg
// types and codes shared by the sorted list engine, its sequencer and its checker
// ----------------------------------------------------------------------------
package sle_pkg;

  localparam int unsigned ItemW   = 32;
  localparam int unsigned OpW     = 3;
  localparam int unsigned StatusW = 2;
  localparam int unsigned LengthW = 7;

  typedef enum logic [OpW-1:0] {
    OP_INSERT       = 3'd0,
    OP_DELETE       = 3'd1,
    OP_RETRIEVE     = 3'd2,
    OP_GET_NEXT     = 3'd3,
    OP_RESET_CURSOR = 3'd4,
    OP_MAKE_EMPTY   = 3'd5
  } opcode_e;

  typedef enum logic [StatusW-1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_EMPTY     = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_CMP,
    S_INS_PUT,
    S_SCAN,
    S_GET,
    S_FIN
  } sle_state_e;

  typedef struct packed {
    logic [OpW-1:0]   opcode;
    logic [ItemW-1:0] item_in;
  } sle_in_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic               found;
    logic [ItemW-1:0]   item_out;
    logic [LengthW-1:0] length;
  } sle_out_t;

endpackage

### src/sle_ram.sv
// ----------------------------------------------------------------------------
// sle_ram
// entry store: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module sle_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned DW    = 32,
  parameter int unsigned AW    = 6
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/sle_ctrl.sv
// ----------------------------------------------------------------------------
// sle_ctrl
// sequencer: walks the entry store to insert, delete, look up and read out
// ----------------------------------------------------------------------------
module sle_ctrl #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned VW    = 32,
  parameter int unsigned AW    = 6,
  parameter int unsigned CW    = 7
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sle_pkg::sle_in_t  in_data_i,
  output logic              res_valid_o,
  input  logic              res_stall_i,
  output sle_pkg::sle_out_t res_data_o,
  output logic              mem_we_o,
  output logic [AW-1:0]     mem_waddr_o,
  output logic [VW-1:0]     mem_wdata_o,
  output logic              mem_re_o,
  output logic [AW-1:0]     mem_raddr_o,
  input  logic [VW-1:0]     mem_rdata_i
);
  import sle_pkg::*;

  sle_state_e    state_q, state_d;
  opcode_e       op_q, op_d;
  status_e       status_q, status_d;
  logic [VW-1:0] val_q, val_d;
  logic [VW-1:0] item_q, item_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [AW-1:0] cursor_q, cursor_d;
  logic          hit_q, hit_d;
  logic          found_q, found_d;

  logic [CW-1:0] cnt_m1, idx_m1, idx_m2, idx_p1, get_nxt;
  logic [AW-1:0] get_ptr;
  logic          last, match;

  assign cnt_m1  = count_q - 1'b1;
  assign idx_m1  = idx_q - 1'b1;
  assign idx_m2  = idx_q - 2'd2;
  assign idx_p1  = idx_q + 1'b1;
  assign last    = (idx_p1 == count_q);
  assign match   = (mem_rdata_i == val_q);
  assign get_ptr = (CW'(cursor_q) >= count_q) ? cnt_m1[AW-1:0] : cursor_q;
  assign get_nxt = CW'(get_ptr) + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      cursor_q <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      cursor_q <= cursor_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    status_q <= status_d;
    val_q    <= val_d;
    item_q   <= item_d;
    idx_q    <= idx_d;
    hit_q    <= hit_d;
    found_q  <= found_d;
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    status_d    = status_q;
    val_d       = val_q;
    item_d      = item_q;
    count_d     = count_q;
    idx_d       = idx_q;
    cursor_d    = cursor_q;
    hit_d       = hit_q;
    found_d     = found_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = idx_q[AW-1:0];
    mem_wdata_o = val_q;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;
    res_valid_o = 1'b0;
    in_stall_o  = (state_q != S_IDLE);

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d     = opcode_e'(in_data_i.opcode);
          val_d    = in_data_i.item_in[VW-1:0];
          status_d = STAT_OK;
          found_d  = 1'b0;
          item_d   = '0;
          hit_d    = 1'b0;
          state_d  = S_FIN;
          case (op_d)
            OP_INSERT: begin
              if (count_q == CW'(DEPTH)) begin
                status_d = STAT_FULL;
              end else if (count_q == '0) begin
                idx_d   = '0;
                state_d = S_INS_PUT;
              end else begin
                mem_re_o    = 1'b1;
                mem_raddr_o = cnt_m1[AW-1:0];
                idx_d       = count_q;
                state_d     = S_INS_CMP;
              end
            end
            OP_DELETE, OP_RETRIEVE: begin
              if (count_q == '0) begin
                if (op_d == OP_DELETE) status_d = STAT_EMPTY;
              end else begin
                mem_re_o    = 1'b1;
                mem_raddr_o = '0;
                idx_d       = '0;
                state_d     = S_SCAN;
              end
            end
            OP_GET_NEXT: begin
              if (count_q == '0) begin
                status_d = STAT_EMPTY;
              end else begin
                mem_re_o    = 1'b1;
                mem_raddr_o = get_ptr;
                cursor_d    = (get_nxt < count_q) ? get_nxt[AW-1:0] : get_ptr;
                state_d     = S_GET;
              end
            end
            OP_RESET_CURSOR: begin
              cursor_d = '0;
            end
            OP_MAKE_EMPTY: begin
              count_d  = '0;
              cursor_d = '0;
            end
            default: ;
          endcase
        end
      end

      // read data holds the entry just below idx
      S_INS_CMP: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = idx_q[AW-1:0];
        if (mem_rdata_i >= val_q) begin
          mem_wdata_o = mem_rdata_i;
          idx_d       = idx_m1;
          if (idx_m1 != '0) begin
            mem_re_o    = 1'b1;
            mem_raddr_o = idx_m2[AW-1:0];
          end else begin
            state_d = S_INS_PUT;
          end
        end else begin
          mem_wdata_o = val_q;
          count_d     = count_q + 1'b1;
          state_d     = S_FIN;
        end
      end

      S_INS_PUT: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = idx_q[AW-1:0];
        mem_wdata_o = val_q;
        count_d     = count_q + 1'b1;
        state_d     = S_FIN;
      end

      // read data holds the entry at idx
      S_SCAN: begin
        if (!last) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = idx_p1[AW-1:0];
          idx_d       = idx_p1;
        end
        if (op_q == OP_RETRIEVE) begin
          if (match) begin
            found_d = 1'b1;
            state_d = S_FIN;
          end else if (last) begin
            state_d = S_FIN;
          end
        end else begin
          if (hit_q) begin
            mem_we_o    = 1'b1;
            mem_waddr_o = idx_m1[AW-1:0];
            mem_wdata_o = mem_rdata_i;
          end
          if (match) hit_d = 1'b1;
          if (last) begin
            state_d = S_FIN;
            if (hit_q || match) begin
              count_d = cnt_m1;
            end else begin
              status_d = STAT_NOT_FOUND;
            end
          end
        end
      end

      S_GET: begin
        item_d  = mem_rdata_i;
        state_d = S_FIN;
      end

      S_FIN: begin
        res_valid_o = 1'b1;
        if (!res_stall_i) state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    res_data_o.status   = status_q;
    res_data_o.found    = found_q;
    res_data_o.item_out = ItemW'(item_q);
    res_data_o.length   = LengthW'(count_q);
  end

endmodule

### src/sorted_list_engine.sv
// ----------------------------------------------------------------------------
// sorted_list_engine
// bounded ascending list of values with insert, delete, lookup and cursor read
// ----------------------------------------------------------------------------
// usage:
//   a request (opcode, item_in) is taken when in_valid_i is high and
//   in_stall_o is low; exactly one result (status, found, item_out, length)
//   is offered on out_valid_o and held until out_stall_i is low.
//   one request is worked on at a time; entries sit in a memory with
//   registered read data that the sequencer walks one entry per cycle.
//   insert moves up every entry not below the value and then writes the
//   value, and a full list is answered with no memory access; delete walks
//   the whole list; retrieve stops at its first match, else walks the whole
//   list; get next reads a single entry; other codes touch no entry.
//   the next request can be taken once the result has left the sequencer,
//   even while that result still waits in the output register.
//   reset empties the list and clears the cursor; no clearing pass is needed.
//   a stalled output holds its result and, once the register is occupied and
//   a second result is ready, the sequencer holds off new requests.
// ----------------------------------------------------------------------------
module sorted_list_engine #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sle_pkg::sle_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sle_pkg::sle_out_t out_data_o
);
  import sle_pkg::*;

  localparam int unsigned VW = (WIDTH < ItemW) ? WIDTH : ItemW;
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic          res_valid, res_stall;
  sle_out_t      res_data;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [VW-1:0] mem_wdata, mem_rdata;

  logic          out_valid_q;
  sle_out_t      out_data_q;

  sle_ctrl #(
    .DEPTH (DEPTH),
    .VW    (VW),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .res_valid_o (res_valid),
    .res_stall_i (res_stall),
    .res_data_o  (res_data),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  sle_ram #(
    .DEPTH (DEPTH),
    .DW    (VW),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign res_stall = out_valid_q && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!res_stall) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!res_stall && res_valid) begin
      out_data_q <= res_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### src/sle_checker.sv
// ----------------------------------------------------------------------------
// sle_checker
// port level checks on the sorted list engine results
// ----------------------------------------------------------------------------
module sle_checker #(
  parameter int unsigned DEPTH = 64
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input sle_pkg::sle_in_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input sle_pkg::sle_out_t out_data_o
);
  import sle_pkg::*;

  // a stalled request holds its payload
  a_req_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("request changed while stalled");

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // full is only reported at capacity
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == STAT_FULL) |->
      (out_data_o.length == LengthW'(DEPTH)))
    else $error("full reported below capacity");

  // empty is only reported with no entries and no data
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == STAT_EMPTY) |->
      (out_data_o.length == '0) && (out_data_o.item_out == '0))
    else $error("empty reported with entries");

  // a hit is always an ok result
  a_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.found |-> (out_data_o.status == STAT_OK))
    else $error("hit with error status");

endmodule

bind sorted_list_engine sle_checker #(.DEPTH(DEPTH)) u_sle_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
